FILE: hdl/cafu_pkg.sv
// Package for the CPU ALU and flag execute unit.
// Holds operation codes, status bit positions and shared structs.
// No dependencies.
package cafu_pkg;

  typedef enum logic [5:0] {
    OP_ORA   = 6'd0,
    OP_AND   = 6'd1,
    OP_EOR   = 6'd2,
    OP_ADC   = 6'd3,
    OP_SBC   = 6'd4,
    OP_CMP   = 6'd5,
    OP_CPX   = 6'd6,
    OP_CPY   = 6'd7,
    OP_BIT   = 6'd8,
    OP_ASL_A = 6'd9,
    OP_ASL_M = 6'd10,
    OP_LSR_A = 6'd11,
    OP_LSR_M = 6'd12,
    OP_ROL_A = 6'd13,
    OP_ROL_M = 6'd14,
    OP_ROR_A = 6'd15,
    OP_ROR_M = 6'd16,
    OP_INC   = 6'd17,
    OP_DEC   = 6'd18,
    OP_INX   = 6'd19,
    OP_INY   = 6'd20,
    OP_DEX   = 6'd21,
    OP_DEY   = 6'd22,
    OP_LDA   = 6'd23,
    OP_LDX   = 6'd24,
    OP_LDY   = 6'd25,
    OP_STA   = 6'd26,
    OP_STX   = 6'd27,
    OP_STY   = 6'd28,
    OP_CLC   = 6'd29,
    OP_SEC   = 6'd30,
    OP_CLI   = 6'd31,
    OP_SEI   = 6'd32,
    OP_CLD   = 6'd33,
    OP_SED   = 6'd34,
    OP_CLV   = 6'd35,
    OP_BPL   = 6'd36,
    OP_BMI   = 6'd37,
    OP_BVC   = 6'd38,
    OP_BVS   = 6'd39,
    OP_BCC   = 6'd40,
    OP_BCS   = 6'd41,
    OP_BNE   = 6'd42,
    OP_BEQ   = 6'd43,
    OP_PHA   = 6'd44,
    OP_PHP   = 6'd45,
    OP_PLA   = 6'd46,
    OP_PLP   = 6'd47,
    OP_RTI   = 6'd48,
    OP_NOP   = 6'd49
  } op_t;

  // Status bit positions
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_B = 4;
  localparam int unsigned FL_U = 5;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0] STATUS_RESET = 8'h24;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
  } cpu_regs_t;

  typedef struct packed {
    logic [7:0] write_data;
    logic       write_enable;
    logic       branch_taken;
  } alu_res_t;

endpackage

FILE: hdl/cafu_in_if.sv
// Input channel of the execute unit: operation code and operand byte.
// Uses no package.
interface cafu_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] opcode;
  logic [7:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

FILE: hdl/cafu_out_if.sv
// Result channel of the execute unit: write request, branch test and registers.
// Uses no package.
interface cafu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] write_data;
  logic       write_enable;
  logic       branch_taken;
  logic [7:0] status_out;
  logic [7:0] acc_out;
  logic [7:0] index_x_out;
  logic [7:0] index_y_out;

  modport source (output valid, output write_data, output write_enable,
                  output branch_taken, output status_out, output acc_out,
                  output index_x_out, output index_y_out, input ready);
  modport sink   (input valid, input write_data, input write_enable,
                  input branch_taken, input status_out, input acc_out,
                  input index_x_out, input index_y_out, output ready);
endinterface

FILE: hdl/cpu_alu_flag_execute_unit.sv
// Top level of the CPU ALU and flag execute unit: input register, execute
// logic, architectural registers A/X/Y/P and the result register.
// Depends on cafu_pkg, cafu_in_if, cafu_out_if and cafu_alu.
//
//   channel   dir   beat payload
//   in_ch     in    opcode[5:0], operand[7:0]
//   out_ch    out   write_data, write_enable, branch_taken, status_out,
//                   acc_out, index_x_out, index_y_out
//
// One beat per cycle while the result channel is not stalled; an input beat goes
// through the input register, then execute into the result register.
// A/X/Y/P update as an item leaves the input register, so the next item
// sees them at once. Reset sets A/X/Y to zero and P to 0x24.
// A stalled result holds the result register and, behind it, the input register.
module cpu_alu_flag_execute_unit
  import cafu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  cafu_in_if.sink    in_ch,
  cafu_out_if.source out_ch
);

  logic       stage_valid;
  logic [5:0] stage_opcode;
  logic [7:0] stage_operand;
  logic       stage_advance;

  cpu_regs_t  regs;
  cpu_regs_t  regs_next;
  alu_res_t   res;

  logic       out_valid;
  alu_res_t   out_res;
  cpu_regs_t  out_regs;

  assign stage_advance = stage_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready   = !stage_valid || stage_advance;

  cafu_alu u_alu (
    .opcode    (stage_opcode),
    .operand   (stage_operand),
    .regs      (regs),
    .regs_next (regs_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_opcode  <= in_ch.opcode;
      stage_operand <= in_ch.operand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.acc <= 8'h00;
      regs.x   <= 8'h00;
      regs.y   <= 8'h00;
      regs.p   <= STATUS_RESET;
    end else if (stage_advance) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      out_res  <= res;
      out_regs <= regs_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.write_data   = out_res.write_data;
  assign out_ch.write_enable = out_res.write_enable;
  assign out_ch.branch_taken = out_res.branch_taken;
  assign out_ch.status_out   = out_regs.p;
  assign out_ch.acc_out      = out_regs.acc;
  assign out_ch.index_x_out  = out_regs.x;
  assign out_ch.index_y_out  = out_regs.y;

endmodule

FILE: hdl/cafu_alu.sv
// Combinational execute logic: ALU, shifter, branch test and status flag update.
// Depends on cafu_pkg.
module cafu_alu
  import cafu_pkg::*;
(
  input  logic [5:0] opcode,
  input  logic [7:0] operand,
  input  cpu_regs_t  regs,
  output cpu_regs_t  regs_next,
  output alu_res_t   res
);

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q       = p;
    q[FL_N] = v[7];
    q[FL_Z] = (v == 8'h00);
    return q;
  endfunction

  op_t        op;
  logic [7:0] a;
  logic [7:0] m;
  logic       cin;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [8:0] cmp_diff;
  logic [7:0] cmp_reg;
  logic [7:0] r;

  assign op  = op_t'(opcode);
  assign a   = regs.acc;
  assign m   = operand;
  assign cin = regs.p[FL_C];

  assign sum  = {1'b0, a} + {1'b0, m} + {8'h00, cin};
  assign diff = {1'b0, a} - {1'b0, m} - {8'h00, ~cin};

  always_comb begin
    case (op)
      OP_CPX:  cmp_reg = regs.x;
      OP_CPY:  cmp_reg = regs.y;
      default: cmp_reg = a;
    endcase
  end

  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

  always_comb begin
    regs_next        = regs;
    res.write_data   = 8'h00;
    res.write_enable = 1'b0;
    res.branch_taken = 1'b0;
    r                = 8'h00;
    case (op)
      OP_ORA: begin
        r = a | m;
        regs_next.acc = r;
        regs_next.p   = with_nz(regs.p, r);
      end
      OP_AND: begin
        r = a & m;
        regs_next.acc = r;
        regs_next.p   = with_nz(regs.p, r);
      end
      OP_EOR: begin
        r = a ^ m;
        regs_next.acc = r;
        regs_next.p   = with_nz(regs.p, r);
      end
      OP_ADC: begin
        r = sum[7:0];
        regs_next.acc     = r;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = sum[8];
        regs_next.p[FL_V] = (m[7] ^ r[7]) & (a[7] ^ r[7]);
      end
      OP_SBC: begin
        r = diff[7:0];
        regs_next.acc     = r;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = ~diff[8];
        regs_next.p[FL_V] = (a[7] ^ m[7]) & (a[7] ^ r[7]);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        regs_next.p       = with_nz(regs.p, cmp_diff[7:0]);
        regs_next.p[FL_C] = ~cmp_diff[8];
      end
      OP_BIT: begin
        regs_next.p[FL_V] = m[6];
        regs_next.p[FL_N] = m[7];
        regs_next.p[FL_Z] = ((m & a) == 8'h00);
      end
      OP_ASL_A: begin
        r = {a[6:0], 1'b0};
        regs_next.acc     = r;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = a[7];
      end
      OP_LSR_A: begin
        r = {1'b0, a[7:1]};
        regs_next.acc     = r;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = a[0];
      end
      OP_ROL_A: begin
        r = {a[6:0], cin};
        regs_next.acc     = r;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = a[7];
      end
      OP_ROR_A: begin
        r = {cin, a[7:1]};
        regs_next.acc     = r;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = a[0];
      end
      OP_ASL_M: begin
        r = {m[6:0], 1'b0};
        res.write_data    = r;
        res.write_enable  = 1'b1;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = m[7];
      end
      OP_LSR_M: begin
        r = {1'b0, m[7:1]};
        res.write_data    = r;
        res.write_enable  = 1'b1;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = m[0];
      end
      OP_ROL_M: begin
        r = {m[6:0], cin};
        res.write_data    = r;
        res.write_enable  = 1'b1;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = m[7];
      end
      OP_ROR_M: begin
        r = {cin, m[7:1]};
        res.write_data    = r;
        res.write_enable  = 1'b1;
        regs_next.p       = with_nz(regs.p, r);
        regs_next.p[FL_C] = m[0];
      end
      OP_INC: begin
        r = m + 8'h01;
        res.write_data   = r;
        res.write_enable = 1'b1;
        regs_next.p      = with_nz(regs.p, r);
      end
      OP_DEC: begin
        r = m - 8'h01;
        res.write_data   = r;
        res.write_enable = 1'b1;
        regs_next.p      = with_nz(regs.p, r);
      end
      OP_INX: begin
        r = regs.x + 8'h01;
        regs_next.x = r;
        regs_next.p = with_nz(regs.p, r);
      end
      OP_INY: begin
        r = regs.y + 8'h01;
        regs_next.y = r;
        regs_next.p = with_nz(regs.p, r);
      end
      OP_DEX: begin
        r = regs.x - 8'h01;
        regs_next.x = r;
        regs_next.p = with_nz(regs.p, r);
      end
      OP_DEY: begin
        r = regs.y - 8'h01;
        regs_next.y = r;
        regs_next.p = with_nz(regs.p, r);
      end
      OP_LDA, OP_PLA: begin
        regs_next.acc = m;
        regs_next.p   = with_nz(regs.p, m);
      end
      OP_LDX: begin
        regs_next.x = m;
        regs_next.p = with_nz(regs.p, m);
      end
      OP_LDY: begin
        regs_next.y = m;
        regs_next.p = with_nz(regs.p, m);
      end
      OP_STA, OP_PHA: begin
        res.write_data   = a;
        res.write_enable = 1'b1;
      end
      OP_STX: begin
        res.write_data   = regs.x;
        res.write_enable = 1'b1;
      end
      OP_STY: begin
        res.write_data   = regs.y;
        res.write_enable = 1'b1;
      end
      OP_CLC: regs_next.p[FL_C] = 1'b0;
      OP_SEC: regs_next.p[FL_C] = 1'b1;
      OP_CLI: regs_next.p[FL_I] = 1'b0;
      OP_SEI: regs_next.p[FL_I] = 1'b1;
      OP_CLD: regs_next.p[FL_D] = 1'b0;
      OP_SED: regs_next.p[FL_D] = 1'b1;
      OP_CLV: regs_next.p[FL_V] = 1'b0;
      OP_BPL: res.branch_taken = ~regs.p[FL_N];
      OP_BMI: res.branch_taken =  regs.p[FL_N];
      OP_BVC: res.branch_taken = ~regs.p[FL_V];
      OP_BVS: res.branch_taken =  regs.p[FL_V];
      OP_BCC: res.branch_taken = ~regs.p[FL_C];
      OP_BCS: res.branch_taken =  regs.p[FL_C];
      OP_BNE: res.branch_taken = ~regs.p[FL_Z];
      OP_BEQ: res.branch_taken =  regs.p[FL_Z];
      OP_PHP: begin
        // push with break and unused bits forced high
        res.write_data         = regs.p;
        res.write_data[FL_B]   = 1'b1;
        res.write_data[FL_U]   = 1'b1;
        res.write_enable       = 1'b1;
      end
      OP_PLP, OP_RTI: begin
        regs_next.p       = m;
        regs_next.p[FL_B] = 1'b0;
        regs_next.p[FL_U] = 1'b1;
      end
      default: ;  // NOP and unassigned codes
    endcase
  end

endmodule
